>>> rtl/core/itp_pkg.sv
// Shared types, character codes and the digit decoder for the integer text parser.
// No dependencies; used by every module under rtl/core.
package itp_pkg;

	localparam int unsigned MaxOffset  = 255;
	localparam int unsigned OffsetW    = $clog2(MaxOffset + 1);
	localparam int unsigned ValueW     = 32;
	localparam int unsigned CharW      = 8;
	localparam int unsigned RadixW     = 6;
	localparam int unsigned DigitW     = 7;
	localparam int unsigned EndOffsetW = 8;

	localparam logic [CharW-1:0] ChNul   = 8'h00;
	localparam logic [CharW-1:0] ChSpace = 8'h20;
	localparam logic [CharW-1:0] ChPlus  = 8'h2B;
	localparam logic [CharW-1:0] ChMinus = 8'h2D;
	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChNine  = 8'h39;
	localparam logic [CharW-1:0] ChUpA   = 8'h41;
	localparam logic [CharW-1:0] ChUpF   = 8'h46;
	localparam logic [CharW-1:0] ChUpX   = 8'h58;
	localparam logic [CharW-1:0] ChLowA  = 8'h61;
	localparam logic [CharW-1:0] ChLowF  = 8'h66;
	localparam logic [CharW-1:0] ChLowX  = 8'h78;

	localparam logic [RadixW-1:0] BaseAuto = 6'd0;
	localparam logic [RadixW-1:0] BaseOct  = 6'd8;
	localparam logic [RadixW-1:0] BaseDec  = 6'd10;
	localparam logic [RadixW-1:0] BaseHex  = 6'd16;

	localparam logic [DigitW-1:0] DigitNone = 7'd64;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_LEAD   = 5'b00010,
		PH_POST   = 5'b00100,
		PH_ZERO   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [ValueW-1:0]   acc;
		logic [OffsetW-1:0]  consumed;
		logic                negative;
		logic [RadixW-1:0]   base;
		logic                mode_signed;
	} state_t;

	typedef struct packed {
		logic                  emit;
		logic [ValueW-1:0]     value;
		logic [EndOffsetW-1:0] end_offset;
	} result_t;

	// Digit value of a character, or DigitNone when it is no digit at all.
	function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
		logic [DigitW-1:0] d;
		d = DigitNone;
		if (c >= ChZero && c <= ChNine)
			d = DigitW'(c - ChZero);
		else if (c >= ChLowA && c <= ChLowF)
			d = DigitW'(c - ChLowA) + DigitW'(10);
		else if (c >= ChUpA && c <= ChUpF)
			d = DigitW'(c - ChUpA) + DigitW'(10);
		return d;
	endfunction

endpackage

>>> rtl/core/itp_step.sv
// Next-state and result logic for one character of the parser.
// Depends on itp_pkg.
module itp_step (
	input  itp_pkg::state_t                  cur,
	input  logic [itp_pkg::CharW-1:0]        ch,
	input  logic [itp_pkg::RadixW-1:0]       radix,
	input  logic                             signed_mode,
	output itp_pkg::state_t                  nxt,
	output itp_pkg::result_t                 res
);

	itp_pkg::state_t                s;
	logic                           done;
	logic                           cnt;
	logic [itp_pkg::DigitW-1:0]     d;
	logic [itp_pkg::ValueW-1:0]     prod;

	assign d    = itp_pkg::digit_of(ch);

	always_comb begin
		s    = cur;
		done = 1'b0;
		cnt  = 1'b0;
		prod = '0;
		res  = '0;
		nxt  = cur;

		if (cur.phase == itp_pkg::PH_START) begin
			s.base        = radix;
			s.mode_signed = signed_mode;
			s.negative    = 1'b0;
			s.acc         = '0;
			s.consumed    = '0;
			s.phase       = signed_mode ? itp_pkg::PH_LEAD : itp_pkg::PH_POST;
		end

		if (s.phase == itp_pkg::PH_LEAD) begin
			if (ch == itp_pkg::ChSpace) begin
				cnt  = 1'b1;
				done = 1'b1;
			end else if (ch == itp_pkg::ChMinus || ch == itp_pkg::ChPlus) begin
				s.negative = (ch == itp_pkg::ChMinus);
				s.phase    = itp_pkg::PH_POST;
				cnt        = 1'b1;
				done       = 1'b1;
			end else begin
				s.phase = itp_pkg::PH_POST;
			end
		end

		if (!done) begin
			if (s.phase == itp_pkg::PH_POST) begin
				if (ch == itp_pkg::ChSpace) begin
					cnt  = 1'b1;
					done = 1'b1;
				end else if (ch == itp_pkg::ChZero &&
						(s.base == itp_pkg::BaseAuto || s.base == itp_pkg::BaseHex)) begin
					// hold the zero: it may open a hex prefix
					s.phase = itp_pkg::PH_ZERO;
					cnt     = 1'b1;
					done    = 1'b1;
				end else begin
					if (s.base == itp_pkg::BaseAuto)
						s.base = itp_pkg::BaseDec;
					s.phase = itp_pkg::PH_DIGITS;
				end
			end else if (s.phase == itp_pkg::PH_ZERO) begin
				if (ch == itp_pkg::ChLowX || ch == itp_pkg::ChUpX) begin
					s.base  = itp_pkg::BaseHex;
					s.phase = itp_pkg::PH_DIGITS;
					cnt     = 1'b1;
					done    = 1'b1;
				end else begin
					if (s.base == itp_pkg::BaseAuto)
						s.base = itp_pkg::BaseOct;
					s.phase = itp_pkg::PH_DIGITS;
				end
			end
		end

		if (!done) begin
			if (ch == itp_pkg::ChNul || d >= itp_pkg::DigitW'(s.base)) begin
				res.emit       = 1'b1;
				res.value      = s.negative ? (itp_pkg::ValueW'(0) - s.acc) : s.acc;
				res.end_offset = s.consumed[itp_pkg::EndOffsetW-1:0];
				s.phase        = itp_pkg::PH_START;
			end else begin
				prod    = s.acc * itp_pkg::ValueW'(s.base);
				s.acc   = prod + itp_pkg::ValueW'(d);
				s.phase = itp_pkg::PH_DIGITS;
				cnt     = 1'b1;
			end
		end

		if (cnt && s.consumed < itp_pkg::OffsetW'(itp_pkg::MaxOffset))
			s.consumed = s.consumed + itp_pkg::OffsetW'(1);

		nxt = s;
	end

endmodule

>>> rtl/core/itp_out.sv
// Result register with valid/stall handshake towards the consumer.
// Depends on itp_pkg.
module itp_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  itp_pkg::result_t                   res,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [itp_pkg::ValueW-1:0]         value,
	output logic [itp_pkg::EndOffsetW-1:0]     end_offset,
	output logic                               blocked
);

	logic                               valid_q;
	logic [itp_pkg::ValueW-1:0]         value_q;
	logic [itp_pkg::EndOffsetW-1:0]     offset_q;

	assign blocked    = valid_q && out_stall;
	assign out_valid  = valid_q;
	assign value      = value_q;
	assign end_offset = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= res.value;
			offset_q <= res.end_offset;
		end
	end

endmodule

>>> rtl/core/integer_text_parser_unit.sv
// Streaming strtol/strtoul-style parser: one character word in, one result word per number.
// An accepted character word is registered in the input stage, then its result in the result register (itp_out).
// Throughput: 1 character word per cycle while in_stall is low; the parse state (accumulator, base, phase)
// updates through one 32x6 multiply-add, which sets the clock path.
// Reset: arst_n clears the parse state to the start of a new string and drops all
// held words; no clearing pass is needed.
module integer_text_parser_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [itp_pkg::CharW-1:0]          ch,
	input  logic [itp_pkg::RadixW-1:0]         radix,
	input  logic                               signed_mode,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [itp_pkg::ValueW-1:0]         value,
	output logic [itp_pkg::EndOffsetW-1:0]     end_offset
);

	// Input stage: holds one character word with its sampled radix and mode.
	logic                               valid_s1;
	logic [itp_pkg::CharW-1:0]          ch_s1;
	logic [itp_pkg::RadixW-1:0]         radix_s1;
	logic                               signed_s1;

	// Parse state carried from character to character.
	itp_pkg::state_t                    state_q;
	itp_pkg::state_t                    state_nxt;
	itp_pkg::result_t                   res;

	logic                               out_blocked;
	logic                               s1_fire;
	logic                               load;

	itp_step u_step (
		.cur         (state_q),
		.ch          (ch_s1),
		.radix       (radix_s1),
		.signed_mode (signed_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	// Advance the held word unless it would emit into a full, stalled result register.
	assign s1_fire  = valid_s1 && !(res.emit && out_blocked);
	assign load     = s1_fire && res.emit;
	assign in_stall = valid_s1 && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1     <= ch;
			radix_s1  <= radix;
			signed_s1 <= signed_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: itp_pkg::PH_START, acc: '0, consumed: '0,
				negative: 1'b0, base: '0, mode_signed: 1'b0};
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	itp_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.res        (res),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.value      (value),
		.end_offset (end_offset),
		.blocked    (out_blocked)
	);

	// Never overwrite a result that is still waiting on a stalled consumer.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && out_valid && out_stall))
		else $error("result overwritten while stalled");

	// A terminating character returns the parser to the start of a new string.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q.phase == itp_pkg::PH_START))
		else $error("parser did not restart after result");

	// Phase register stays one-hot.
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.phase))
		else $error("phase not one-hot");

	// Consumed count saturates and never passes its ceiling.
	a_offset_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.consumed <= itp_pkg::OffsetW'(itp_pkg::MaxOffset))
		else $error("consumed count past saturation");

endmodule
